// ===== hdl/sync_length_frame_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// sync_length_frame_parser_top_macros
// assertion macros shared by the deframer checker
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_PARSER_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slfp assertion failed");

// next-cycle implication, disabled in reset
`define SLFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slfp assertion failed");

`endif

// ===== hdl/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// types and constants of the sync/length/checksum frame deframer
// ----------------------------------------------------------------------------
package slfp_pkg;

  localparam logic [7:0] SYNC_FIRST      = 8'hB5;
  localparam logic [7:0] SYNC_SECOND     = 8'hCA;
  localparam logic [8:0] FRAME_OVERHEAD  = 9'd5;
  localparam logic [8:0] MAX_FRAME_RESET = 9'd64;
  localparam int         CNT_W           = 16;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [5:0] {
    PH_SYNC1 = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_ID    = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_PAY   = 6'b010000,
    PH_CHK   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [7:0]       byte_index;
    logic             frame_done;
    logic [7:0]       message_id;
    logic [7:0]       payload_length;
    logic             checksum_ok;
    logic             sync_dropped;
    logic             oversize_dropped;
    logic [CNT_W-1:0] discarded_count;
  } result_t;

endpackage

// ===== hdl/slfp_parser.sv =====
// ----------------------------------------------------------------------------
// slfp_parser
// frame state machine, running checksum and discard counter; one byte per transfer
// ----------------------------------------------------------------------------
module slfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  output slfp_pkg::result_t   res
);

  slfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  frame_id_r, frame_id_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [slfp_pkg::CNT_W-1:0] drop_r, drop_nxt;
  logic [8:0]  max_r;

  logic [8:0]  drop_amt;
  logic [slfp_pkg::CNT_W:0] drop_sum;
  logic [8:0]  frame_size;
  logic [7:0]  cnt_inc;

  assign frame_size = {1'b0, frame_len_r} + slfp_pkg::FRAME_OVERHEAD;
  assign cnt_inc    = pay_cnt_r + 8'd1;
  assign drop_sum   = {1'b0, drop_r} + {{(slfp_pkg::CNT_W - 8){1'b0}}, drop_amt};

  always_comb begin
    phase_nxt     = phase_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    pay_cnt_nxt   = pay_cnt_r;
    sum_nxt       = sum_r;
    drop_amt      = 9'd0;
    res           = '0;
    case (phase_r)
      slfp_pkg::PH_SYNC2: begin
        if (rx_byte == slfp_pkg::SYNC_SECOND) begin
          phase_nxt = slfp_pkg::PH_ID;
        end else begin
          drop_amt         = 9'd2;
          res.sync_dropped = 1'b1;
          phase_nxt        = slfp_pkg::PH_SYNC1;
        end
      end
      slfp_pkg::PH_ID: begin
        frame_id_nxt = rx_byte;
        sum_nxt      = rx_byte;
        phase_nxt    = slfp_pkg::PH_LEN;
      end
      slfp_pkg::PH_LEN: begin
        frame_len_nxt = rx_byte;
        sum_nxt       = sum_r + rx_byte;
        pay_cnt_nxt   = 8'd0;
        phase_nxt     = (rx_byte == 8'd0) ? slfp_pkg::PH_CHK : slfp_pkg::PH_PAY;
      end
      slfp_pkg::PH_PAY: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.byte_index    = pay_cnt_r;
        sum_nxt           = sum_r + rx_byte;
        pay_cnt_nxt       = cnt_inc;
        if (cnt_inc >= frame_len_r) begin
          phase_nxt = slfp_pkg::PH_CHK;
        end
      end
      slfp_pkg::PH_CHK: begin
        if (frame_size > max_r) begin
          drop_amt             = frame_size;
          res.oversize_dropped = 1'b1;
        end else begin
          res.frame_done     = 1'b1;
          res.message_id     = frame_id_r;
          res.payload_length = frame_len_r;
          res.checksum_ok    = (rx_byte == sum_r);
        end
        pay_cnt_nxt = 8'd0;
        phase_nxt   = slfp_pkg::PH_SYNC1;
      end
      default: begin
        if (rx_byte == slfp_pkg::SYNC_FIRST) begin
          phase_nxt = slfp_pkg::PH_SYNC2;
        end else begin
          drop_amt         = 9'd1;
          res.sync_dropped = 1'b1;
          phase_nxt        = slfp_pkg::PH_SYNC1;
        end
      end
    endcase
    drop_nxt            = drop_sum[slfp_pkg::CNT_W] ? slfp_pkg::CNT_MAX
                                                    : drop_sum[slfp_pkg::CNT_W-1:0];
    res.discarded_count = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= slfp_pkg::PH_SYNC1;
      frame_id_r  <= '0;
      frame_len_r <= '0;
      pay_cnt_r   <= '0;
      sum_r       <= '0;
      drop_r      <= '0;
      max_r       <= slfp_pkg::MAX_FRAME_RESET;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      if (step) begin
        phase_r     <= phase_nxt;
        frame_id_r  <= frame_id_nxt;
        frame_len_r <= frame_len_nxt;
        pay_cnt_r   <= pay_cnt_nxt;
        sum_r       <= sum_nxt;
        drop_r      <= drop_nxt;
      end
    end
  end

endmodule

// ===== hdl/slfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// slfp_out_reg
// result register with valid flag; holds a result until the receiver takes it
// ----------------------------------------------------------------------------
module slfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  slfp_pkg::result_t res_in,
  input  logic              take,
  output logic              valid,
  output slfp_pkg::result_t res_out
);

  logic              valid_r;
  slfp_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// ===== hdl/sync_length_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_parser_top
// byte-serial deframer for B5 CA id length payload checksum frames
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one received byte per transfer in in_tdata
//   out_* : one result per input byte; flags in out_tuser, fields in out_tdata
//   cfg_* : write of max_frame_bytes, always ready, only while idle
// output: a result appears in the cycle after its byte transfer
// throughput: one byte per cycle while out_tready is high; the result register
//   lets the next byte in while the last result is taken
// stall: while out_tready is low a waiting result holds and in_tready drops,
//   so no byte is taken until the result register frees up
// reset: rst_n low clears the result register's valid flag, returns the parser to the
//   first sync byte, clears the discard counter and sets the limit to 64
// ----------------------------------------------------------------------------
module sync_length_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // payload_byte, byte_index, message_id,
                                   // payload_length, checksum_ok, discarded_count
  output logic [3:0]  out_tuser,   // payload_valid, frame_done, sync_dropped,
                                   // oversize_dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data     // max_frame_bytes
);

  slfp_pkg::result_t res;
  slfp_pkg::result_t res_q;
  logic              step;

  assign in_tready = !out_tvalid || out_tready;
  assign step      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  slfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (in_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  slfp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step),
    .res_in  (res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tdata = {7'd0, res_q.discarded_count, res_q.checksum_ok,
                      res_q.payload_length, res_q.message_id,
                      res_q.byte_index, res_q.payload_byte};
  assign out_tuser = {res_q.oversize_dropped, res_q.sync_dropped,
                      res_q.frame_done, res_q.payload_valid};

endmodule

// ===== hdl/slfp_checker.sv =====
// ----------------------------------------------------------------------------
// slfp_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "sync_length_frame_parser_top_macros.svh"

module slfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [3:0]  out_tuser
);

  logic [60:0] out_word;

  assign out_word = {out_tvalid, out_tdata, out_tuser};

  `SLFP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))
  `SLFP_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready)
  `SLFP_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid)
  `SLFP_ASSERT_NOW(a_one_kind, out_tvalid, $onehot0(out_tuser))
  `SLFP_ASSERT_NOW(a_no_payload_zero, out_tvalid && !out_tuser[0], out_tdata[15:0] == 16'd0)

endmodule

bind sync_length_frame_parser_top slfp_checker u_slfp_checker (.*);
